/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked outside reset
`define MSS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define MSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mss_pkg.sv */
`default_nettype none

package mss_pkg;

	localparam int MAX_MOTORS = 16;
	localparam int CODE_W     = 3;
	localparam int CODES_W    = 48;
	localparam int SENSOR_W   = 5;
	localparam int TRACK_W    = 8;
	localparam int WAIT_W     = 16;
	localparam int STEP_W     = 7;
	localparam int LINES_W    = 8;
	localparam int SLOT_W     = 6;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_STEP   = 2'd1,
		KIND_SENSOR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CODE_OFF   = 3'd0,
		CODE_ON    = 3'd1,
		CODE_ARM_A = 3'd2,
		CODE_ARM_B = 3'd3
	} motor_code_t;

	typedef enum logic [1:0] {
		ARM_NONE = 2'd0,
		ARM_A    = 2'd1,
		ARM_B    = 2'd2
	} arm_t;

	typedef enum logic [1:0] {
		CFG_STEP_COUNT = 2'd0,
		CFG_EXT_MASK   = 2'd1,
		CFG_REPORT     = 2'd2
	} cfg_reg_t;

	// one program step as stored
	typedef struct packed {
		logic [CODES_W-1:0] codes;
		logic [TRACK_W-1:0] track;
		logic [WAIT_W-1:0]  wait_units;
	} prog_word_t;

	// fields of a transaction that the execute stage still needs
	typedef struct packed {
		logic [1:0]          kind;
		logic                trigger;
		logic [LINES_W-1:0]  base_sensors;
		logic [LINES_W-1:0]  ext_lines;
		logic [SLOT_W-1:0]   slot;
		logic [SENSOR_W-1:0] sensor_a;
		logic [SENSOR_W-1:0] sensor_b;
	} item_t;

	typedef struct packed {
		logic [STEP_W-1:0]  step_count;
		logic [LINES_W-1:0] ext_motor_mask;
		logic               report_steps;
	} cfg_t;

	typedef struct packed {
		logic [MAX_MOTORS-1:0] motor_drive;
		logic                  running;
		logic [STEP_W-1:0]     current_step;
		logic [TRACK_W-1:0]    music_play;
		logic                  step_entered;
	} result_t;

	// 1 when the chosen sensor reads low (reached); numbers outside 1..16 read low
	function automatic logic sensor_reached(input logic [SENSOR_W-1:0] sel,
			input logic [2*LINES_W-1:0] sens);
		logic [SENSOR_W-1:0] idx;
		idx = sel - 5'd1;
		if (sel != 5'd0 && sel <= 5'd16) begin
			return ~sens[idx[3:0]];
		end
		return 1'b1;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/mss_prog_mem.sv */
`default_nettype none

module mss_prog_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW-1:0]      waddr,
	input  wire mss_pkg::prog_word_t wdata,
	input  wire logic               re,
	input  wire logic [AW-1:0]      raddr,
	output mss_pkg::prog_word_t     rdata_q
);

	mss_pkg::prog_word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/mss_seq_core.sv */
`default_nettype none

`include "assert_macros.svh"

module mss_seq_core #(
	parameter int MAX_STEPS      = 64,
	parameter int MOTORS         = 16,
	parameter int TICKS_PER_UNIT = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                exec_en,
	input  wire mss_pkg::item_t      item,
	input  wire mss_pkg::prog_word_t prog,
	input  wire mss_pkg::cfg_t       cfg,
	output logic [((($clog2(MAX_STEPS+2)) > 7) ? $clog2(MAX_STEPS+2) : 7)-1:0] sn_next,
	output mss_pkg::result_t         res
);

	localparam int SNW = $clog2(MAX_STEPS + 2);
	localparam int NW  = (SNW > mss_pkg::STEP_W) ? SNW : mss_pkg::STEP_W;
	localparam int TW  = $clog2(TICKS_PER_UNIT + 1);

	logic [MOTORS-1:0]           motor_on_q, motor_on_d;
	logic [1:0]                  arm_q [MOTORS];
	logic [1:0]                  arm_d [MOTORS];
	logic [2*mss_pkg::SENSOR_W-1:0] ssel_q [MOTORS];
	logic [2*mss_pkg::SENSOR_W-1:0] ssel_d [MOTORS];
	logic                        run_q, run_d;
	logic                        lp_q, lp_d;
	logic [NW-1:0]               sn_q, sn_d;
	logic [TW-1:0]               td_q, td_d;
	logic [mss_pkg::WAIT_W-1:0]  wl_q, wl_d;
	logic [mss_pkg::TRACK_W-1:0] music;
	logic                        entered;
	logic [NW-1:0]               count;
	logic [NW-1:0]               cnt_raw;
	logic [2*mss_pkg::LINES_W-1:0] sens;

	assign sens    = {item.ext_lines, item.base_sensors};
	assign cnt_raw = NW'(cfg.step_count);

	always_comb begin
		if (cnt_raw == '0) begin
			count = NW'(1);
		end else if (cnt_raw > NW'(MAX_STEPS)) begin
			count = NW'(MAX_STEPS);
		end else begin
			count = cnt_raw;
		end
	end

	always_comb begin
		logic [mss_pkg::SENSOR_W-1:0] sel;
		logic [TW-1:0]                td_inc;
		logic [NW-1:0]                sn_inc;
		logic [mss_pkg::CODE_W-1:0]   code;
		motor_on_d = motor_on_q;
		arm_d      = arm_q;
		ssel_d     = ssel_q;
		run_d      = run_q;
		lp_d       = lp_q;
		sn_d       = sn_q;
		td_d       = td_q;
		wl_d       = wl_q;
		music      = '0;
		entered    = 1'b0;
		sel        = '0;
		td_inc     = td_q + TW'(1);
		sn_inc     = sn_q + NW'(1);
		code       = '0;
		unique case (item.kind)
			mss_pkg::KIND_SENSOR: begin
				for (int m = 0; m < MOTORS; m++) begin
					if (mss_pkg::SLOT_W'(m) == item.slot) begin
						ssel_d[m] = {item.sensor_b, item.sensor_a};
					end
				end
			end
			mss_pkg::KIND_TICK: begin
				// stop check runs on the state before this tick's step entry
				for (int m = 0; m < MOTORS; m++) begin
					sel = (arm_q[m] == mss_pkg::ARM_A) ? ssel_q[m][4:0] : ssel_q[m][9:5];
					if ((arm_q[m] == mss_pkg::ARM_A || arm_q[m] == mss_pkg::ARM_B) &&
							mss_pkg::sensor_reached(sel, sens)) begin
						arm_d[m]      = mss_pkg::ARM_NONE;
						motor_on_d[m] = 1'b0;
					end
				end
				run_d = run_q | item.trigger;
				if (run_d) begin
					td_d = td_inc;
					if (lp_q) begin
						for (int m = 0; m < MOTORS; m++) begin
							code = prog.codes[mss_pkg::CODE_W*m +: mss_pkg::CODE_W];
							unique case (code)
								mss_pkg::CODE_OFF:   motor_on_d[m] = 1'b0;
								mss_pkg::CODE_ON:    motor_on_d[m] = 1'b1;
								mss_pkg::CODE_ARM_A: arm_d[m] = mss_pkg::ARM_A;
								mss_pkg::CODE_ARM_B: arm_d[m] = mss_pkg::ARM_B;
								default: ;
							endcase
						end
						music   = prog.track;
						wl_d    = prog.wait_units;
						entered = cfg.report_steps;
						lp_d    = 1'b0;
					end
					if (td_inc >= TW'(TICKS_PER_UNIT)) begin
						td_d = '0;
						wl_d = wl_d - 16'd1;
						if (wl_d == '0) begin
							lp_d = 1'b1;
							if (sn_inc > count) begin
								sn_d  = NW'(1);
								run_d = 1'b0;
							end else begin
								sn_d = sn_inc;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_on_q <= '0;
			for (int m = 0; m < MOTORS; m++) begin
				arm_q[m]  <= mss_pkg::ARM_NONE;
				ssel_q[m] <= '0;
			end
			run_q <= 1'b0;
			lp_q  <= 1'b1;
			sn_q  <= NW'(1);
			td_q  <= '0;
			wl_q  <= '0;
		end else if (exec_en) begin
			motor_on_q <= motor_on_d;
			arm_q      <= arm_d;
			ssel_q     <= ssel_d;
			run_q      <= run_d;
			lp_q       <= lp_d;
			sn_q       <= sn_d;
			td_q       <= td_d;
			wl_q       <= wl_d;
		end
	end

	// forwarded so the next tick's program read sees this transaction's step
	assign sn_next = exec_en ? sn_d : sn_q;

	assign res.motor_drive  = mss_pkg::MAX_MOTORS'(motor_on_d) &
		{cfg.ext_motor_mask, 8'hFF};
	assign res.running      = run_d;
	assign res.current_step = sn_d[mss_pkg::STEP_W-1:0];
	assign res.music_play   = music;
	assign res.step_entered = entered;

	`MSS_ASSERT(a_step_range, clk, arst_n, (sn_q != '0) && (sn_q <= NW'(MAX_STEPS)), "step number out of range")
	`MSS_ASSERT_IMP(a_idle_loads, clk, arst_n, !run_q, lp_q, "idle sequencer without pending step load")
	`MSS_ASSERT(a_div_range, clk, arst_n, td_q < TW'(TICKS_PER_UNIT), "tick divider past its limit")

endmodule

`default_nettype wire

/* rtl/core/motor_step_sequencer_with_stops.sv */
`default_nettype none

// Channel   Signals                                                   Dir
// --------  --------------------------------------------------------  ---
// in        in_valid/in_ready, kind, trigger, base_sensors,           in
//           ext_lines, slot, motor_codes, music_track, wait_units,
//           sensor_a, sensor_b
// out       out_valid/out_ready, motor_drive, running, current_step,  out
//           music_play, step_entered
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data                  in
//
// One transaction per cycle unless the output stalls; the execute stage result goes to an output register.
// The program memory is read at acceptance with the step number left by the
// transaction in the execute stage, so its registered read is hidden.
// Program writes land at acceptance, cfg writes on handshake; other state updates in the execute stage.
// Reset: motors off, stops disarmed, sensor selections zero, sequencer idle at step 1.
// Program memory has no reset. A stalled output holds the execute stage, which holds input.

`include "assert_macros.svh"

module motor_step_sequencer_with_stops #(
	parameter int MAX_STEPS      = 64,
	parameter int MOTORS         = 16,
	parameter int TICKS_PER_UNIT = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic        trigger,
	input  wire logic [7:0]  base_sensors,
	input  wire logic [7:0]  ext_lines,
	input  wire logic [5:0]  slot,
	input  wire logic [47:0] motor_codes,
	input  wire logic [7:0]  music_track,
	input  wire logic [15:0] wait_units,
	input  wire logic [4:0]  sensor_a,
	input  wire logic [4:0]  sensor_b,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      motor_drive,
	output logic             running,
	output logic [6:0]       current_step,
	output logic [7:0]       music_play,
	output logic             step_entered,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam int AW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int SNW = $clog2(MAX_STEPS + 2);
	localparam int NW  = (SNW > mss_pkg::STEP_W) ? SNW : mss_pkg::STEP_W;

	mss_pkg::cfg_t       cfg_q;
	mss_pkg::item_t      item_s1;
	logic                s1_valid_q;
	logic                s1_adv;
	logic                exec_en;
	logic                accept;
	logic                mem_we;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	mss_pkg::prog_word_t mem_wdata;
	mss_pkg::prog_word_t mem_rdata;
	logic [NW-1:0]       sn_next;
	mss_pkg::result_t    res;
	mss_pkg::result_t    res_q;
	logic                out_valid_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_count     <= 7'd1;
			cfg_q.ext_motor_mask <= '0;
			cfg_q.report_steps   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mss_pkg::CFG_STEP_COUNT: cfg_q.step_count     <= cfg_data[6:0];
				mss_pkg::CFG_EXT_MASK:   cfg_q.ext_motor_mask <= cfg_data;
				mss_pkg::CFG_REPORT:     cfg_q.report_steps   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake
	assign s1_adv   = !out_valid_q || out_ready;
	assign exec_en  = s1_valid_q && s1_adv;
	assign in_ready = !s1_valid_q || s1_adv;
	assign accept   = in_valid && in_ready;

	// program memory
	assign mem_we    = accept && (kind == mss_pkg::KIND_STEP) && (32'(slot) < MAX_STEPS);
	assign mem_re    = accept && (kind == mss_pkg::KIND_TICK);
	assign mem_raddr = AW'(sn_next - NW'(1));
	assign mem_wdata = '{codes: motor_codes, track: music_track, wait_units: wait_units};

	mss_prog_mem #(
		.DEPTH (MAX_STEPS),
		.AW    (AW)
	) u_prog_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (AW'(slot)),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	// execute stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{kind: kind, trigger: trigger, base_sensors: base_sensors,
				ext_lines: ext_lines, slot: slot, sensor_a: sensor_a, sensor_b: sensor_b};
		end
	end

	mss_seq_core #(
		.MAX_STEPS      (MAX_STEPS),
		.MOTORS         (MOTORS),
		.TICKS_PER_UNIT (TICKS_PER_UNIT)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.exec_en (exec_en),
		.item    (item_s1),
		.prog    (mem_rdata),
		.cfg     (cfg_q),
		.sn_next (sn_next),
		.res     (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign motor_drive  = res_q.motor_drive;
	assign running      = res_q.running;
	assign current_step = res_q.current_step;
	assign music_play   = res_q.music_play;
	assign step_entered = res_q.step_entered;

	`MSS_ASSERT_NXT(a_s1_hold, clk, arst_n, s1_valid_q && !s1_adv, s1_valid_q, "execute stage lost a stalled transaction")

endmodule

`default_nettype wire
